>>> design/tas_pkg.sv
// Shared types and constants for the triangle area statistics block.
package tas_pkg;
  localparam int unsigned AreaBits  = 51;
  localparam int unsigned SumBits   = 64;
  localparam int unsigned IdxBits   = 2;

  typedef enum logic [IdxBits-1:0] {
    REG_DEGENERATE = 2'd0,
    REG_TINY       = 2'd1,
    REG_SMALL      = 2'd2,
    REG_MEDIUM     = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    CLS_TINY   = 2'd0,
    CLS_SMALL  = 2'd1,
    CLS_MEDIUM = 2'd2,
    CLS_LARGE  = 2'd3
  } area_class_e;

  typedef logic [AreaBits-1:0] area_t;

  typedef struct packed {
    area_t degenerate;
    area_t tiny;
    area_t small_lim;
    area_t medium_lim;
  } limits_t;
endpackage

>>> design/triangle_area_statistics.sv
// Top level: triangle area and per-set area statistics.
// Usage:
//  Triangles enter through push_i/full_o as nine signed corner coordinates and
//  a new_set_i flag. Results leave through empty_o/pop_i; the oldest result is
//  on the result ports while empty_o is low.
//  Limits are written through cfg_valid_i/cfg_ready_o with an index 0..3;
//  other indices are dropped. Write them only while the block is idle.
//  The front end is a 5-stage pipeline (edges, products, cross product,
//  partial squares, squares) feeding an 8-entry queue. The back end computes
//  the square root one bit per cycle after a start step, then updates the
//  statistics and holds the result until the receiver pops it; it starts the
//  next triangle from the queue only after that pop.
//  Reset clears the limits, the statistics and all queues.
//  A stalled receiver holds the back end; the front keeps accepting until
//  its queue holds two or more entries, then raises full_o.
module triangle_area_statistics #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic full_o,
  input  logic signed [COORD_BITS-1:0] corner0_x_i,
  input  logic signed [COORD_BITS-1:0] corner0_y_i,
  input  logic signed [COORD_BITS-1:0] corner0_z_i,
  input  logic signed [COORD_BITS-1:0] corner1_x_i,
  input  logic signed [COORD_BITS-1:0] corner1_y_i,
  input  logic signed [COORD_BITS-1:0] corner1_z_i,
  input  logic signed [COORD_BITS-1:0] corner2_x_i,
  input  logic signed [COORD_BITS-1:0] corner2_y_i,
  input  logic signed [COORD_BITS-1:0] corner2_z_i,
  input  logic new_set_i,
  output logic empty_o,
  input  logic pop_i,
  output logic [tas_pkg::AreaBits-1:0] area_o,
  output logic [1:0] area_class_o,
  output logic [COUNT_BITS-1:0] tri_total_o,
  output logic [tas_pkg::SumBits-1:0] area_total_o,
  output logic [tas_pkg::AreaBits-1:0] area_least_o,
  output logic [tas_pkg::AreaBits-1:0] area_greatest_o,
  output logic [COUNT_BITS-1:0] tiny_total_o,
  output logic [COUNT_BITS-1:0] small_total_o,
  output logic [COUNT_BITS-1:0] medium_total_o,
  output logic [COUNT_BITS-1:0] large_total_o,
  output logic [COUNT_BITS-1:0] degenerate_total_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import tas_pkg::*;

  localparam int unsigned QW = 4 * COORD_BITS + 6;

  limits_t lim_q;
  logic f_vld, f_ns, q_empty, busy, done;
  logic [QW-1:0] f_sq, q_sq;
  logic [2:0] lvl;
  logic [QW:0] q_data;
  logic [4*COUNT_BITS-1:0] cc;
  logic start;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lim_q <= '0;
    else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_DEGENERATE: lim_q.degenerate <= cfg_data_i[AreaBits-1:0];
        REG_TINY:       lim_q.tiny       <= cfg_data_i[AreaBits-1:0];
        REG_SMALL:      lim_q.small_lim  <= cfg_data_i[AreaBits-1:0];
        REG_MEDIUM:     lim_q.medium_lim <= cfg_data_i[AreaBits-1:0];
        default: ;
      endcase
    end
  end

  // queue of 8 minus 5 pipeline stages in flight, one entry spare
  assign full_o = (lvl >= 3'd2);

  tas_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i, .rst_ni, .adv_i(1'b1), .in_valid_i(push_i && !full_o),
    .coords_i({corner2_z_i, corner2_y_i, corner2_x_i, corner1_z_i, corner1_y_i,
               corner1_x_i, corner0_z_i, corner0_y_i, corner0_x_i}),
    .new_set_i, .out_valid_o(f_vld), .sq_o(f_sq), .new_set_o(f_ns));

  assign start = !q_empty && !busy;

  tas_fifo #(.W(QW + 1)) u_fifo (
    .clk_i, .rst_ni, .wr_i(f_vld), .wdata_i({f_ns, f_sq}), .rd_i(start),
    .rdata_o(q_data), .empty_o(q_empty), .level_o(lvl));

  assign q_sq = q_data[QW-1:0];

  tas_back #(.COORD_BITS(COORD_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk_i, .rst_ni, .lim_i(lim_q), .start_i(start), .sq_i(q_sq),
    .new_set_i(q_data[QW]), .busy_o(busy), .done_o(done), .area_o,
    .cls_o(area_class_o), .tri_o(tri_total_o), .sum_o(area_total_o),
    .min_o(area_least_o), .max_o(area_greatest_o), .cls_cnt_o(cc),
    .deg_o(degenerate_total_o), .res_take_i(pop_i));

  assign empty_o = !done;
  assign tiny_total_o   = cc[0 +: COUNT_BITS];
  assign small_total_o  = cc[COUNT_BITS +: COUNT_BITS];
  assign medium_total_o = cc[2*COUNT_BITS +: COUNT_BITS];
  assign large_total_o  = cc[3*COUNT_BITS +: COUNT_BITS];

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> !done) else $error("start while result pending");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_vld |-> lvl != 3'd7) else $error("queue overflow");
  a_pop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !empty_o) |=> empty_o) else $error("result repeated");
`endif
endmodule

>>> design/tas_front.sv
// Front end: edge vectors, cross product and squared length, pipelined.
module tas_front #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic                    in_valid_i,
  input  logic [9*COORD_BITS-1:0] coords_i,
  input  logic                    new_set_i,
  output logic                    out_valid_o,
  output logic [4*COORD_BITS+5:0] sq_o,
  output logic                    new_set_o
);
  import tas_pkg::*;

  localparam int unsigned EW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * EW;
  localparam int unsigned CW = PW + 1;
  localparam int unsigned MW = CW - 1;
  localparam int unsigned H  = MW / 2;
  localparam int unsigned SW = 2 * MW;
  localparam int unsigned QW = 4 * COORD_BITS + 6;

  logic [4:0] vld_q;
  logic [4:0] ns_q;

  logic signed [COORD_BITS-1:0] p [9];
  logic signed [EW-1:0] e_d [6];
  logic signed [EW-1:0] e_q [6];
  logic signed [PW-1:0] pr_q [6];
  logic signed [CW-1:0] c_d [3];
  logic [MW-1:0] m_q [3];
  logic [2*H-1:0] hh_q [3];
  logic [2*H-1:0] hl_q [3];
  logic [2*H-1:0] ll_q [3];
  logic [SW-1:0] s_q [3];

  always_comb begin
    for (int i = 0; i < 9; i++) p[i] = coords_i[i*COORD_BITS +: COORD_BITS];
    for (int i = 0; i < 3; i++) begin
      e_d[i]   = EW'(p[3+i]) - EW'(p[i]);
      e_d[3+i] = EW'(p[6+i]) - EW'(p[i]);
    end
    c_d[0] = CW'(pr_q[0]) - CW'(pr_q[1]);
    c_d[1] = CW'(pr_q[2]) - CW'(pr_q[3]);
    c_d[2] = CW'(pr_q[4]) - CW'(pr_q[5]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      ns_q  <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[3:0], in_valid_i};
      ns_q  <= {ns_q[3:0], new_set_i};
    end
  end

  // e: ux uy uz vx vy vz
  // squares built from half-width products over two stages
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      e_q <= e_d;
      pr_q[0] <= e_q[1] * e_q[5];
      pr_q[1] <= e_q[2] * e_q[4];
      pr_q[2] <= e_q[2] * e_q[3];
      pr_q[3] <= e_q[0] * e_q[5];
      pr_q[4] <= e_q[0] * e_q[4];
      pr_q[5] <= e_q[1] * e_q[3];
      for (int i = 0; i < 3; i++)
        m_q[i] <= c_d[i][CW-1] ? MW'(-c_d[i]) : MW'(c_d[i]);
      for (int i = 0; i < 3; i++) begin
        hh_q[i] <= m_q[i][MW-1:H] * m_q[i][MW-1:H];
        hl_q[i] <= m_q[i][MW-1:H] * m_q[i][H-1:0];
        ll_q[i] <= m_q[i][H-1:0] * m_q[i][H-1:0];
      end
      for (int i = 0; i < 3; i++)
        s_q[i] <= (SW'(hh_q[i]) << (2*H)) + (SW'(hl_q[i]) << (H+1)) + SW'(ll_q[i]);
    end
  end

  assign out_valid_o = vld_q[4];
  assign new_set_o   = ns_q[4];
  assign sq_o = QW'(s_q[0]) + QW'(s_q[1]) + QW'(s_q[2]);
endmodule

>>> design/tas_fifo.sv
// Short queue between front and back end.
module tas_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_i,
  input  logic [W-1:0] wdata_i,
  input  logic         rd_i,
  output logic [W-1:0] rdata_o,
  output logic         empty_o,
  output logic [2:0]   level_o
);
  logic [W-1:0] mem_q [8];
  logic [2:0] wp_q, rp_q;
  logic [3:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= wp_q + 3'd1;
      if (rd_i) rp_q <= rp_q + 3'd1;
      cnt_q <= cnt_q + 4'(wr_i) - 4'(rd_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  assign rdata_o = mem_q[rp_q];
  assign empty_o = (cnt_q == 4'd0);
  assign level_o = cnt_q[3] ? 3'd7 : cnt_q[2:0];
endmodule

>>> design/tas_back.sv
// Back end: bit-serial square root, classification and statistics update.
module tas_back #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tas_pkg::limits_t          lim_i,
  input  logic                      start_i,
  input  logic [4*COORD_BITS+5:0]   sq_i,
  input  logic                      new_set_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [tas_pkg::AreaBits-1:0] area_o,
  output logic [1:0]                cls_o,
  output logic [COUNT_BITS-1:0]     tri_o,
  output logic [tas_pkg::SumBits-1:0] sum_o,
  output logic [tas_pkg::AreaBits-1:0] min_o,
  output logic [tas_pkg::AreaBits-1:0] max_o,
  output logic [4*COUNT_BITS-1:0]   cls_cnt_o,
  output logic [COUNT_BITS-1:0]     deg_o,
  input  logic                      res_take_i
);
  import tas_pkg::*;

  localparam int unsigned QW = 4 * COORD_BITS + 6;
  localparam int unsigned RW = QW / 2;
  localparam int unsigned RC = $clog2(RW + 1);
  localparam int unsigned XW = (RW > AreaBits) ? RW : AreaBits;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  typedef enum logic [1:0] {S_IDLE, S_ROOT, S_UPD, S_HOLD} st_e;
  st_e st_q;

  logic [QW-1:0] rem_q, val_q;
  logic [RW-1:0] root_q;
  logic [RC-1:0] it_q;
  logic ns_q;
  logic [COUNT_BITS-1:0] tri_q, deg_q;
  logic [COUNT_BITS-1:0] cc_q [4];
  logic [SumBits-1:0] sum_q;
  area_t min_q, max_q, area_q;
  logic [1:0] cls_q;

  logic [QW+1:0] trial;
  logic [QW-1:0] shv;
  logic [XW-1:0] half;
  area_t area_w;
  logic [1:0] cls_w;
  logic [SumBits:0] sum_w;

  // restoring square root, one result bit per cycle
  always_comb begin
    shv   = QW'({rem_q, val_q[QW-1 -: 2]});
    trial = (QW+2)'({rem_q, val_q[QW-1 -: 2]}) - (QW+2)'({root_q, 2'b01});
    half  = XW'(root_q >> 1);
    area_w = (half > XW'({AreaBits{1'b1}})) ? '1 : AreaBits'(half);
    if (area_w < lim_i.tiny) cls_w = CLS_TINY;
    else if (area_w < lim_i.small_lim) cls_w = CLS_SMALL;
    else if (area_w < lim_i.medium_lim) cls_w = CLS_MEDIUM;
    else cls_w = CLS_LARGE;
    sum_w = (SumBits+1)'(ns_q ? '0 : sum_q) + (SumBits+1)'(area_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      tri_q <= '0; deg_q <= '0; sum_q <= '0; min_q <= '0; max_q <= '0;
      for (int i = 0; i < 4; i++) cc_q[i] <= '0;
      it_q <= '0; ns_q <= 1'b0;
    end else begin
      unique case (st_q)
        S_IDLE: if (start_i) begin
          st_q <= S_ROOT; it_q <= RC'(RW); ns_q <= new_set_i;
        end
        S_ROOT: begin
          it_q <= it_q - RC'(1);
          if (it_q == RC'(1)) st_q <= S_UPD;
        end
        S_UPD: begin
          logic [COUNT_BITS-1:0] t, d, c;
          t = ns_q ? '0 : tri_q;
          d = ns_q ? '0 : deg_q;
          c = ns_q ? '0 : cc_q[cls_w];
          for (int i = 0; i < 4; i++) begin
            if (2'(i) == cls_w) cc_q[i] <= (c == CMAX) ? c : c + 1'b1;
            else if (ns_q) cc_q[i] <= '0;
          end
          tri_q <= (t == CMAX) ? t : t + 1'b1;
          if (area_w <= lim_i.degenerate) deg_q <= (d == CMAX) ? d : d + 1'b1;
          else deg_q <= d;
          if (t == '0 || area_w < min_q) min_q <= area_w;
          if (ns_q) max_q <= area_w;
          else if (area_w > max_q) max_q <= area_w;
          sum_q <= sum_w[SumBits] ? '1 : sum_w[SumBits-1:0];
          st_q <= S_HOLD;
        end
        S_HOLD: if (res_take_i) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && start_i) begin
      rem_q <= '0; val_q <= sq_i; root_q <= '0;
    end else if (st_q == S_ROOT) begin
      val_q <= val_q << 2;
      if (!trial[QW+1]) begin
        rem_q <= QW'(trial); root_q <= {root_q[RW-2:0], 1'b1};
      end else begin
        rem_q <= shv; root_q <= {root_q[RW-2:0], 1'b0};
      end
    end
    if (st_q == S_UPD) begin
      area_q <= area_w; cls_q <= cls_w;
    end
  end

  assign busy_o  = (st_q != S_IDLE);
  assign done_o  = (st_q == S_HOLD);
  assign area_o  = area_q;
  assign cls_o   = cls_q;
  assign tri_o   = tri_q;
  assign sum_o   = sum_q;
  assign min_o   = min_q;
  assign max_o   = max_q;
  assign deg_o   = deg_q;
  assign cls_cnt_o = {cc_q[3], cc_q[2], cc_q[1], cc_q[0]};
endmodule
